>>> sv/urbe_pkg.sv
// urbe_pkg: shared types and constants for the serial-port ring buffer engine.
// Used by urbe_queue and uart_ring_buffer_engine; depends on nothing.

package urbe_pkg;

  // Byte width of every queued item
  localparam int unsigned ByteW = 8;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OpHostWrite = 2'd0,
    OpHostRead  = 2'd1,
    OpTxDone    = 2'd2,
    OpRxByte    = 2'd3
  } op_e;

  // Commands from the control logic to one queue
  typedef struct packed {
    logic             load;  // step is processed: capture head data
    logic             push;  // append wdata at the tail
    logic             pop;   // advance the head
    logic [ByteW-1:0] wdata;
  } q_cmd_t;

  // Status of one queue before the current step
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/uart_ring_buffer_engine.sv
// uart_ring_buffer_engine: transmit and receive byte queues for a serial port.
// Depends on urbe_pkg and urbe_queue.

// The block takes one beat per cycle while no result waits (host write, host
// read, transmit done or received byte) and returns exactly one result beat
// for each, held first in the input register and then in the result register,
// with the head byte of each queue read from its memory into the result
// register. Each queue holds TX_DEPTH-1 or RX_DEPTH-1 bytes; a write
// or received byte that finds its queue full is discarded and flagged as
// dropped. A host write while the transmitter is idle hands the head byte to
// the transmitter in the same step, and transmit done hands over the next
// one or leaves the transmitter idle. tx_byte and read_byte read zero when
// their flags are low. Input is stalled only while a result waits.

module uart_ring_buffer_engine #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       tx_start_o,
  output logic [7:0] tx_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       dropped_o,
  output logic       tx_idle_o
);

  logic                       in_valid_q;
  urbe_pkg::op_e              op_q;
  logic [urbe_pkg::ByteW-1:0] data_q;
  logic                       out_valid_q;
  logic                       start_q, read_valid_q, dropped_q, idle_out_q;
  logic                       xmit_idle_q, xmit_idle_d;
  logic                       advance, process, in_accept;
  logic                       start_d, read_valid_d, dropped_d;
  logic                       kick, have_byte;
  urbe_pkg::q_cmd_t           tx_cmd, rx_cmd;
  urbe_pkg::q_stat_t          tx_stat, rx_stat;
  logic [urbe_pkg::ByteW-1:0] tx_rdata, rx_rdata;

  // Handshake: the input register fills while the result register waits
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Hold the accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= urbe_pkg::op_e'(operation_i);
      data_q <= data_i;
    end
  end

  // Decode the step into queue commands and result flags
  always_comb begin
    tx_cmd       = '0;
    rx_cmd       = '0;
    tx_cmd.load  = process;
    rx_cmd.load  = process;
    tx_cmd.wdata = data_q;
    rx_cmd.wdata = data_q;
    kick         = 1'b0;
    read_valid_d = 1'b0;
    dropped_d    = 1'b0;
    unique case (op_q)
      urbe_pkg::OpHostWrite: begin
        tx_cmd.push = process && !tx_stat.full;
        dropped_d   = tx_stat.full;
        kick        = xmit_idle_q;
      end
      urbe_pkg::OpHostRead: begin
        rx_cmd.pop   = process && !rx_stat.empty;
        read_valid_d = !rx_stat.empty;
      end
      urbe_pkg::OpTxDone: begin
        kick = 1'b1;
      end
      urbe_pkg::OpRxByte: begin
        rx_cmd.push = process && !rx_stat.full;
        dropped_d   = rx_stat.full;
      end
      default: begin
        kick = 1'b0;
      end
    endcase
    // A byte just written counts as queued for the transmitter
    have_byte   = !tx_stat.empty || (op_q == urbe_pkg::OpHostWrite && !tx_stat.full);
    start_d     = kick && have_byte;
    tx_cmd.pop  = process && start_d;
    xmit_idle_d = kick ? !have_byte : xmit_idle_q;
  end

  // Track the transmitter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmit_idle_q <= 1'b1;
    end else if (process) begin
      xmit_idle_q <= xmit_idle_d;
    end
  end

  urbe_queue #(
    .DEPTH (TX_DEPTH)
  ) u_tx_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tx_cmd),
    .stat_o  (tx_stat),
    .rdata_o (tx_rdata)
  );

  urbe_queue #(
    .DEPTH (RX_DEPTH)
  ) u_rx_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rx_cmd),
    .stat_o  (rx_stat),
    .rdata_o (rx_rdata)
  );

  // Result register: load on process, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      start_q      <= start_d;
      read_valid_q <= read_valid_d;
      dropped_q    <= dropped_d;
      idle_out_q   <= xmit_idle_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_start_o   = start_q;
  assign tx_byte_o    = start_q ? tx_rdata : '0;
  assign read_valid_o = read_valid_q;
  assign read_byte_o  = read_valid_q ? rx_rdata : '0;
  assign dropped_o    = dropped_q;
  assign tx_idle_o    = idle_out_q;

`ifndef SYNTHESIS
  // A handed-over byte always leaves the transmitter busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && start_q |-> !idle_out_q)
    else $error("tx_start with transmitter idle");

  // One result never both returns a read and starts a byte or drops one
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(start_q && read_valid_q) && !(read_valid_q && dropped_q))
    else $error("conflicting result flags");

  // Result flag matches the transmitter state it was taken from
  a_idle_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> idle_out_q == xmit_idle_q)
    else $error("tx_idle result out of step with transmitter");

  // A waiting beat is held while the result stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q && $stable(data_q))
    else $error("input beat lost under stall");
`endif

endmodule

>>> sv/urbe_queue.sv
// urbe_queue: circular byte queue that keeps one slot empty (DEPTH-1 bytes).
// Depends on urbe_pkg for the command and status structs.

module urbe_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  urbe_pkg::q_cmd_t           cmd_i,
  output urbe_pkg::q_stat_t          stat_o,
  output logic [urbe_pkg::ByteW-1:0] rdata_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  logic [urbe_pkg::ByteW-1:0] mem [DEPTH];
  logic [urbe_pkg::ByteW-1:0] rdata_q;
  logic [PtrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]            wr_ptr_inc, rd_ptr_inc;
  logic                       bypass;

  // Wrap the pointers at the last slot
  assign wr_ptr_inc = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_ptr_inc = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);

  assign stat_o.empty = (rd_ptr_q == wr_ptr_q);
  assign stat_o.full  = (wr_ptr_inc == rd_ptr_q);

  // A byte pushed into an empty queue is the head in the same step
  assign bypass = cmd_i.push && stat_o.empty;

  assign wr_ptr_d = cmd_i.push ? wr_ptr_inc : wr_ptr_q;
  assign rd_ptr_d = cmd_i.pop  ? rd_ptr_inc : rd_ptr_q;

  // Advance the pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Write the tail entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= cmd_i.wdata;
    end
  end

  // Capture the head entry, hold it while the result waits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= bypass ? cmd_i.wdata : mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/tb_uart_ring_buffer_engine.sv
`timescale 1ns / 100ps
// tb_uart_ring_buffer_engine: self-checking bench for the serial-port ring buffer engine.
// Depends on urbe_pkg and the uart_ring_buffer_engine RTL; predicts every result beat.

module tb_uart_ring_buffer_engine;

  localparam int unsigned TxDepth     = 16;
  localparam int unsigned RxDepth     = 16;
  localparam int unsigned TxPtrW      = $clog2(TxDepth);
  localparam int unsigned RxPtrW      = $clog2(RxDepth);
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned IdlePct     = 18;

  typedef struct packed {
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       dropped;
    logic       tx_idle;
  } uart_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] operation_i;
  logic [7:0] data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       tx_start_o;
  logic [7:0] tx_byte_o;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       dropped_o;
  logic       tx_idle_o;

  uart_ring_buffer_engine #(
    .TX_DEPTH(TxDepth),
    .RX_DEPTH(RxDepth)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_start_o  (tx_start_o),
    .tx_byte_o   (tx_byte_o),
    .read_valid_o(read_valid_o),
    .read_byte_o (read_byte_o),
    .dropped_o   (dropped_o),
    .tx_idle_o   (tx_idle_o)
  );

  // Predicted queue state, mirrors the block after each accepted beat
  logic [7:0]        tx_fifo_mem [TxDepth];
  logic [TxPtrW-1:0] tx_head = '0;
  logic [TxPtrW-1:0] tx_tail = '0;
  logic [7:0]        rx_fifo_mem [RxDepth];
  logic [RxPtrW-1:0] rx_head = '0;
  logic [RxPtrW-1:0] rx_tail = '0;
  logic              tx_is_idle = 1'b1;

  uart_result_t awaited_uart_results [$];

  bit          quiet_mode = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned tx_handoffs = 0;
  int unsigned reads_with_data = 0;
  int unsigned dropped_bytes = 0;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [TxPtrW-1:0] tx_ptr_next(logic [TxPtrW-1:0] p);
    return (p == TxPtrW'(TxDepth - 1)) ? '0 : p + TxPtrW'(1);
  endfunction

  function automatic logic [RxPtrW-1:0] rx_ptr_next(logic [RxPtrW-1:0] p);
    return (p == RxPtrW'(RxDepth - 1)) ? '0 : p + RxPtrW'(1);
  endfunction

  // Hand the transmit head byte over, or go idle when nothing is queued
  function automatic void hand_to_transmitter(inout uart_result_t r);
    if (tx_head == tx_tail) begin
      tx_is_idle = 1'b1;
    end else begin
      r.tx_start = 1'b1;
      r.tx_byte  = tx_fifo_mem[tx_head];
      tx_head    = tx_ptr_next(tx_head);
      tx_is_idle = 1'b0;
    end
  endfunction

  // Advance the predicted queues by one beat and return the result it causes
  function automatic uart_result_t predict_uart_step(urbe_pkg::op_e op, logic [7:0] d);
    uart_result_t r;
    r = '0;
    unique case (op)
      urbe_pkg::OpHostWrite: begin
        if (tx_ptr_next(tx_tail) == tx_head) begin
          r.dropped = 1'b1;
        end else begin
          tx_fifo_mem[tx_tail] = d;
          tx_tail = tx_ptr_next(tx_tail);
        end
        if (tx_is_idle) hand_to_transmitter(r);
      end
      urbe_pkg::OpHostRead: begin
        if (rx_head != rx_tail) begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_fifo_mem[rx_head];
          rx_head = rx_ptr_next(rx_head);
        end
      end
      urbe_pkg::OpTxDone: begin
        hand_to_transmitter(r);
      end
      default: begin
        if (rx_ptr_next(rx_tail) == rx_head) begin
          r.dropped = 1'b1;
        end else begin
          rx_fifo_mem[rx_tail] = d;
          rx_tail = rx_ptr_next(rx_tail);
        end
      end
    endcase
    r.tx_idle = tx_is_idle;
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one beat, with an occasional gap before it, and hold it until accepted
  task automatic send_beat(urbe_pkg::op_e op, logic [7:0] d);
    if (!quiet_mode && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_i      <= d;
    do @(posedge clk_i); while (in_stall_o);
    awaited_uart_results.push_back(predict_uart_step(op, d));
    beats_sent++;
  endtask

  // Check each accepted result beat and drive the output stall
  initial begin : result_monitor
    uart_result_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (awaited_uart_results.size() == 0) begin
          $error("result beat arrived with no expectation pending");
          mismatch_count++;
        end else begin
          want = awaited_uart_results.pop_front();
          check_field("tx_start", 8'(want.tx_start), 8'(tx_start_o));
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("read_valid", 8'(want.read_valid), 8'(read_valid_o));
          check_field("read_byte", want.read_byte, read_byte_o);
          check_field("dropped", 8'(want.dropped), 8'(dropped_o));
          check_field("tx_idle", 8'(want.tx_idle), 8'(tx_idle_o));
          results_checked++;
          tx_handoffs     += 32'(want.tx_start);
          reads_with_data += 32'(want.read_valid);
          dropped_bytes   += 32'(want.dropped);
        end
      end
      // Hold off for a requested stretch, else stall at random
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_cycles--;
      end else begin
        out_stall_i <= !quiet_mode && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Extreme bytes, every operation, empty and idle corner cases
  task automatic test_directed_cases();
    send_beat(urbe_pkg::OpHostRead, 8'hFF);   // read with nothing received
    send_beat(urbe_pkg::OpTxDone, 8'h00);     // transmit done while idle and empty
    send_beat(urbe_pkg::OpHostWrite, 8'h00);  // idle: handed over at once
    send_beat(urbe_pkg::OpHostWrite, 8'hFF);  // busy: queued only
    send_beat(urbe_pkg::OpHostWrite, 8'hA5);
    send_beat(urbe_pkg::OpTxDone, 8'h5A);
    send_beat(urbe_pkg::OpTxDone, 8'hFF);
    send_beat(urbe_pkg::OpTxDone, 8'h00);     // queue drained: go idle
    send_beat(urbe_pkg::OpTxDone, 8'hFF);     // stay idle
    send_beat(urbe_pkg::OpRxByte, 8'hFF);
    send_beat(urbe_pkg::OpRxByte, 8'h00);
    send_beat(urbe_pkg::OpRxByte, 8'h5A);
    send_beat(urbe_pkg::OpHostRead, 8'h00);
    send_beat(urbe_pkg::OpHostRead, 8'hFF);
    send_beat(urbe_pkg::OpHostRead, 8'h00);
    send_beat(urbe_pkg::OpHostRead, 8'h00);   // empty again
    send_beat(urbe_pkg::OpHostWrite, 8'h81);
    send_beat(urbe_pkg::OpRxByte, 8'h7E);
    send_beat(urbe_pkg::OpTxDone, 8'h00);
    send_beat(urbe_pkg::OpHostRead, 8'h00);
  endtask

  // Bursts of one operation fill and drain the queues; mixed bursts add noise
  task automatic test_random_traffic(int unsigned n_beats);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned kind;
    urbe_pkg::op_e op;
    sent = 0;
    while (sent < n_beats) begin
      kind      = $urandom_range(0, 4);
      burst_len = $urandom_range(1, 20);
      for (int unsigned i = 0; i < burst_len; i++) begin
        unique case (kind)
          0:       op = urbe_pkg::OpHostWrite;
          1:       op = urbe_pkg::OpTxDone;
          2:       op = urbe_pkg::OpRxByte;
          3:       op = urbe_pkg::OpHostRead;
          default: op = urbe_pkg::op_e'($urandom_range(0, 3));
        endcase
        send_beat(op, 8'($urandom_range(0, 255)));
      end
      sent += burst_len;
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    test_random_traffic(400);
    quiet_mode = 1'b0;
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    rx_hold_cycles = 300;
    test_random_traffic(80);
  endtask

  initial begin : stimulus
    int unsigned waited;
    in_valid_i  = 1'b0;
    operation_i = urbe_pkg::OpHostWrite;
    data_i      = 8'h00;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(1250);
    test_back_to_back();
    test_output_backpressure();
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    waited = 0;
    while (awaited_uart_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_uart_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_uart_results.size());
      mismatch_count++;
    end

    $display("Covered %0d beats and %0d checked results under random and held-off stalls:",
             beats_sent, results_checked);
    $display("  %0d transmitter handoffs, %0d reads returning data, %0d bytes dropped on full",
             tx_handoffs, reads_with_data, dropped_bytes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/urbe_pkg.sv
sv/urbe_queue.sv
sv/uart_ring_buffer_engine.sv
bench/tb_uart_ring_buffer_engine.sv
